### hdl/pss_pkg.sv
// Shared constants, request codes and controller command type for the step sequencer.
`timescale 1ns / 1ps

package pss_pkg;

    localparam int DEFAULT_ROWS = 64;
    localparam int CHANNELS = 3;

    localparam logic [7:0] SLOT_EMPTY = 8'hFF;
    localparam logic [7:0] SLOT_OFF = 8'hFE;
    localparam logic [6:0] PITCH_MAX = 7'd127;
    localparam logic [3:0] OCTAVE_RESET = 4'd5;

    localparam logic [3:0] REQ_DOWN = 4'd0;
    localparam logic [3:0] REQ_UP = 4'd1;
    localparam logic [3:0] REQ_LEFT = 4'd2;
    localparam logic [3:0] REQ_RIGHT = 4'd3;
    localparam logic [3:0] REQ_NOTE = 4'd4;
    localparam logic [3:0] REQ_RELEASE = 4'd5;
    localparam logic [3:0] REQ_REMOVE = 4'd6;
    localparam logic [3:0] REQ_NOTEOFF = 4'd7;
    localparam logic [3:0] REQ_PLAY = 4'd8;
    localparam logic [3:0] REQ_TICK = 4'd9;

    typedef struct packed {
        logic start;
        logic exec;
    } pss_cmd_t;

endpackage

### hdl/pss_ctrl.sv
// Controller state machine that sequences the pattern read and the update of each word.
`timescale 1ns / 1ps

module pss_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output pss_pkg::pss_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.start = 1'b0;
        cmd.exec = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.exec = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### hdl/pss_datapath.sv
// Datapath with the pattern memory, cursor, playhead, gate and pitch registers.
`timescale 1ns / 1ps

module pss_datapath #(
    parameter int ROWS = pss_pkg::DEFAULT_ROWS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pss_pkg::pss_cmd_t cmd,
    input  logic [3:0]        s_req_type,
    input  logic [4:0]        s_note_offset,
    input  logic              cfg_valid,
    input  logic [3:0]        cfg_octave,
    output logic              m_gate_a,
    output logic              m_gate_b,
    output logic              m_gate_c,
    output logic [6:0]        m_pitch_a,
    output logic [6:0]        m_pitch_b,
    output logic [6:0]        m_pitch_c,
    output logic [5:0]        m_cursor_row,
    output logic [1:0]        m_cursor_channel,
    output logic              m_playing,
    output logic [5:0]        m_playhead_row
);

    localparam int RW = $clog2(ROWS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic [2:0][7:0] mem [ROWS];
    logic [ROWS-1:0] row_valid_reg;

    logic [RW-1:0]   row_reg, row_next;
    logic [1:0]      chan_reg, chan_next;
    logic            run_reg, run_next;
    logic [RW-1:0]   play_reg, play_next;
    logic [2:0]      gate_reg, gate_next;
    logic [6:0]      pitch_reg [3];
    logic [6:0]      pitch_next [3];
    logic [3:0]      octave_reg;

    logic [3:0]      req_reg;
    logic [4:0]      off_reg;
    logic [RW-1:0]   addr_reg;
    logic [2:0][7:0] rd_data_reg;
    logic            rd_valid_reg;

    logic [RW-1:0]   play_inc;
    logic [RW-1:0]   addr_in;
    logic [1:0]      ch;
    logic [2:0][7:0] cur_row;
    logic [2:0][7:0] wr_row;
    logic            wr_en;
    logic [7:0]      note_sum;
    logic [6:0]      note;

    assign play_inc = (play_reg == LAST_ROW) ? '0 : play_reg + 1'b1;
    assign addr_in = (s_req_type == pss_pkg::REQ_TICK) ? play_inc : row_reg;
    assign ch = (chan_reg == 2'd3) ? 2'd0 : chan_reg;
    assign cur_row = rd_valid_reg ? rd_data_reg : {3{pss_pkg::SLOT_EMPTY}};
    assign note_sum = 8'({octave_reg, 3'b000}) + 8'({octave_reg, 2'b00}) + 8'(off_reg);
    assign note = (note_sum > 8'(pss_pkg::PITCH_MAX)) ? pss_pkg::PITCH_MAX : note_sum[6:0];

    always_comb begin
        row_next = row_reg;
        chan_next = chan_reg;
        run_next = run_reg;
        play_next = play_reg;
        gate_next = gate_reg;
        pitch_next = pitch_reg;
        wr_en = 1'b0;
        wr_row = cur_row;
        case (req_reg)
            pss_pkg::REQ_DOWN: begin
                row_next = (row_reg == LAST_ROW) ? '0 : row_reg + 1'b1;
            end
            pss_pkg::REQ_UP: begin
                row_next = (row_reg == '0) ? LAST_ROW : row_reg - 1'b1;
            end
            pss_pkg::REQ_LEFT: begin
                chan_next = (ch == 2'd0) ? 2'd2 : ch - 2'd1;
            end
            pss_pkg::REQ_RIGHT: begin
                chan_next = (ch == 2'd2) ? 2'd0 : ch + 2'd1;
            end
            pss_pkg::REQ_NOTE: begin
                gate_next[ch] = 1'b1;
                pitch_next[ch] = note;
                wr_en = !run_reg;
                wr_row[ch] = {1'b0, note};
            end
            pss_pkg::REQ_RELEASE: begin
                gate_next[ch] = 1'b0;
            end
            pss_pkg::REQ_REMOVE: begin
                wr_en = 1'b1;
                wr_row[ch] = pss_pkg::SLOT_EMPTY;
            end
            pss_pkg::REQ_NOTEOFF: begin
                wr_en = 1'b1;
                wr_row[ch] = pss_pkg::SLOT_OFF;
            end
            pss_pkg::REQ_PLAY: begin
                play_next = LAST_ROW;
                gate_next = 3'b000;
                run_next = !run_reg;
            end
            pss_pkg::REQ_TICK: begin
                if (run_reg) begin
                    play_next = addr_reg;
                    for (int c = 0; c < pss_pkg::CHANNELS; c++) begin
                        if (cur_row[c] == pss_pkg::SLOT_OFF) begin
                            gate_next[c] = 1'b0;
                        end else if (cur_row[c] != pss_pkg::SLOT_EMPTY) begin
                            gate_next[c] = 1'b1;
                            pitch_next[c] = cur_row[c][6:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rd_data_reg <= mem[addr_in];
            rd_valid_reg <= row_valid_reg[addr_in];
            req_reg <= s_req_type;
            off_reg <= s_note_offset;
            addr_reg <= addr_in;
        end
        if (cmd.exec && wr_en) begin
            mem[addr_reg] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            row_reg <= '0;
            chan_reg <= 2'd0;
            run_reg <= 1'b0;
            play_reg <= '0;
            gate_reg <= 3'b000;
            pitch_reg <= '{default: 7'd0};
            octave_reg <= pss_pkg::OCTAVE_RESET;
        end else begin
            if (cfg_valid) begin
                octave_reg <= cfg_octave;
            end
            if (cmd.exec) begin
                if (wr_en) begin
                    row_valid_reg[addr_reg] <= 1'b1;
                end
                row_reg <= row_next;
                chan_reg <= chan_next;
                run_reg <= run_next;
                play_reg <= play_next;
                gate_reg <= gate_next;
                pitch_reg <= pitch_next;
            end
        end
    end

    assign m_gate_a = gate_reg[0];
    assign m_gate_b = gate_reg[1];
    assign m_gate_c = gate_reg[2];
    assign m_pitch_a = pitch_reg[0];
    assign m_pitch_b = pitch_reg[1];
    assign m_pitch_c = pitch_reg[2];
    assign m_cursor_row = 6'(row_reg);
    assign m_cursor_channel = chan_reg;
    assign m_playing = run_reg;
    assign m_playhead_row = 6'(play_reg);

endmodule

### hdl/pattern_step_sequencer.sv
// Top level of the three-channel pattern step sequencer.
//
//   Port group   Direction  Carries
//   s_*          in         one event word: request type and note offset
//   m_*          out        one state word per event: gates, pitches, cursor, playhead
//   cfg_*        in         octave register write
//
// Each event word is accepted in ST_IDLE, which reads its pattern row from the
// single-port pattern memory; ST_EXEC then writes the row back if the request edits it
// and loads the result. The next event word is accepted the cycle after that.
// After reset every pattern row reads as empty through per-row valid bits; no clearing pass.
// A result held by m_ready low keeps one accepted word waiting in ST_EXEC.
`timescale 1ns / 1ps

module pattern_step_sequencer #(
    parameter int ROWS = pss_pkg::DEFAULT_ROWS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_req_type,
    input  logic [4:0] s_note_offset,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_gate_a,
    output logic       m_gate_b,
    output logic       m_gate_c,
    output logic [6:0] m_pitch_a,
    output logic [6:0] m_pitch_b,
    output logic [6:0] m_pitch_c,
    output logic [5:0] m_cursor_row,
    output logic [1:0] m_cursor_channel,
    output logic       m_playing,
    output logic [5:0] m_playhead_row,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_octave
);

    pss_pkg::pss_cmd_t cmd;

    assign cfg_ready = 1'b1;

    pss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pss_datapath #(
        .ROWS (ROWS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_req_type       (s_req_type),
        .s_note_offset    (s_note_offset),
        .cfg_valid        (cfg_valid),
        .cfg_octave       (cfg_octave),
        .m_gate_a         (m_gate_a),
        .m_gate_b         (m_gate_b),
        .m_gate_c         (m_gate_c),
        .m_pitch_a        (m_pitch_a),
        .m_pitch_b        (m_pitch_b),
        .m_pitch_c        (m_pitch_c),
        .m_cursor_row     (m_cursor_row),
        .m_cursor_channel (m_cursor_channel),
        .m_playing        (m_playing),
        .m_playhead_row   (m_playhead_row)
    );

endmodule
